// ===== sv/markup_line_classifier_defines.svh =====
// Assertion macros for the markup line classifier.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef MARKUP_LINE_CLASSIFIER_DEFINES_SVH
`define MARKUP_LINE_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define MLC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled during reset.
`define MLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define MLC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MLC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/mlc_pkg.sv =====
// Shared types, constants and helpers of the markup line classifier.
// No dependencies; used by mlc_front, mlc_queue, mlc_back and the top level.
`default_nettype none

package mlc_pkg;

    localparam int PREFIX_LEN       = 10;
    localparam int LINE_NUMBER_BITS = 16;
    localparam int PREFIX_IDX_BITS  = $clog2(PREFIX_LEN);
    localparam int KEY_CHARS        = 10;
    localparam int KEY_BITS         = 8 * KEY_CHARS;
    localparam int QUEUE_DEPTH      = 2;
    localparam int QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_EOL  = 2'd1,
        CMD_EOT  = 2'd2
    } cmd_t;

    typedef enum logic [4:0] {
        KIND_EOF           = 5'd0,
        KIND_BLANK         = 5'd1,
        KIND_ANCHOR        = 5'd2,
        KIND_ATTRS         = 5'd3,
        KIND_TITLE         = 5'd4,
        KIND_SECTION       = 5'd5,
        KIND_ADMONITION    = 5'd6,
        KIND_COMMENT       = 5'd7,
        KIND_THEMATIC      = 5'd8,
        KIND_PAGEBREAK     = 5'd9,
        KIND_UL            = 5'd10,
        KIND_OL            = 5'd11,
        KIND_DESCTERM      = 5'd12,
        KIND_CONT          = 5'd13,
        KIND_LISTING       = 5'd14,
        KIND_LITERAL       = 5'd15,
        KIND_QUOTE         = 5'd16,
        KIND_EXAMPLE       = 5'd17,
        KIND_SIDEBAR       = 5'd18,
        KIND_OPEN          = 5'd19,
        KIND_COMMENT_BLOCK = 5'd20,
        KIND_TABLE_DELIM   = 5'd21,
        KIND_TABLE_LINE    = 5'd22,
        KIND_MACRO         = 5'd23,
        KIND_DIRECTIVE     = 5'd24,
        KIND_TEXT          = 5'd25
    } line_kind_t;

    // Snapshot of one finished line, handed from the front to the back.
    typedef struct packed {
        logic                        is_eof;
        logic [15:0]                 line_number;
        logic                        seen;
        logic [PREFIX_LEN-1:0][7:0]  prefix;
        logic [3:0]                  tlen;
        logic [7:0]                  tail_last;
        logic [7:0]                  tail_second;
        logic [1:0]                  colon_run;
        logic                        all_colons;
    } line_snap_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    // Fit a line counter value onto the 16-bit result field.
    function automatic logic [15:0] to_line_field(input logic [LINE_NUMBER_BITS-1:0] v);
        logic [31:0] wide;
        wide = 32'(v);
        return wide[15:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/mlc_if.sv =====
// Stream interfaces of the markup line classifier: byte input and line result.
// Depends on nothing but the valid/ready convention.
`default_nettype none

interface mlc_byte_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] char_code;

    modport source (output valid, output cmd, output char_code, input ready);
    modport sink   (input valid, input cmd, input char_code, output ready);
endinterface

interface mlc_line_if;
    logic        valid;
    logic        ready;
    logic [4:0]  line_kind;
    logic [15:0] line_number;

    modport source (output valid, output line_kind, output line_number, input ready);
    modport sink   (input valid, input line_kind, input line_number, output ready);
endinterface

`default_nettype wire

// ===== sv/mlc_front.sv =====
// Front end: accepts bytes, tracks the trimmed line state, pushes line snapshots.
// Depends on mlc_pkg and mlc_byte_if.
`default_nettype none

module mlc_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    mlc_byte_if.sink                   byte_stream,
    input  wire mlc_pkg::queue_status_t q_status,
    output logic                       push,
    output mlc_pkg::line_snap_t        push_data
);

    logic                                   seen_reg, seen_next;
    logic [mlc_pkg::PREFIX_LEN-1:0][7:0]    prefix_reg, prefix_next;
    logic [3:0]                             pos_reg, pos_next;
    logic [3:0]                             tlen_reg, tlen_next;
    logic [7:0]                             prev_reg, prev_next;
    logic [7:0]                             tail_last_reg, tail_last_next;
    logic [7:0]                             tail_second_reg, tail_second_next;
    logic [1:0]                             colon_reg, colon_next;
    logic                                   allc_reg, allc_next;
    logic [mlc_pkg::LINE_NUMBER_BITS-1:0]   cnt_reg, cnt_next;
    logic [mlc_pkg::LINE_NUMBER_BITS-1:0]   next_num;
    logic                                   accept;
    logic                                   sp;
    logic [7:0]                             c;

    assign byte_stream.ready = !q_status.full;
    assign accept = byte_stream.valid && byte_stream.ready;
    assign c  = byte_stream.char_code;
    assign sp = mlc_pkg::is_space(c);
    assign next_num = (cnt_reg != '1) ? cnt_reg + 1'b1 : cnt_reg;

    always_comb
    begin
        push_data.is_eof      = (byte_stream.cmd == mlc_pkg::CMD_EOT);
        push_data.line_number = mlc_pkg::to_line_field(next_num);
        push_data.seen        = seen_reg;
        push_data.prefix      = prefix_reg;
        push_data.tlen        = tlen_reg;
        push_data.tail_last   = tail_last_reg;
        push_data.tail_second = tail_second_reg;
        push_data.colon_run   = colon_reg;
        push_data.all_colons  = allc_reg;
    end

    always_comb
    begin
        seen_next        = seen_reg;
        prefix_next      = prefix_reg;
        pos_next         = pos_reg;
        tlen_next        = tlen_reg;
        prev_next        = prev_reg;
        tail_last_next   = tail_last_reg;
        tail_second_next = tail_second_reg;
        colon_next       = colon_reg;
        allc_next        = allc_reg;
        cnt_next         = cnt_reg;
        push             = 1'b0;
        if (accept)
        begin
            case (byte_stream.cmd)
                mlc_pkg::CMD_BYTE:
                begin
                    // store a byte once the line has started, up to the prefix depth
                    if ((!sp || seen_reg) && (32'(pos_reg) < mlc_pkg::PREFIX_LEN)
                        && (pos_reg < 4'd15))
                    begin
                        prefix_next[pos_reg[mlc_pkg::PREFIX_IDX_BITS-1:0]] = c;
                    end
                    seen_next = seen_reg | !sp;
                    if (!sp)
                    begin
                        tlen_next        = (pos_reg < 4'd15) ? pos_reg + 4'd1 : 4'd15;
                        tail_second_next = prev_reg;
                        tail_last_next   = c;
                        if (c == ":")
                        begin
                            if (prev_reg == ":")
                                colon_next = (colon_reg < 2'd3) ? colon_reg + 2'd1 : 2'd3;
                            else
                                colon_next = 2'd1;
                        end
                        else
                        begin
                            colon_next = 2'd0;
                            allc_next  = 1'b0;
                        end
                    end
                    if (seen_next && (pos_reg < 4'd15))
                        pos_next = pos_reg + 4'd1;
                    prev_next = c;
                end
                mlc_pkg::CMD_EOL:
                begin
                    push     = 1'b1;
                    cnt_next = next_num;
                end
                mlc_pkg::CMD_EOT:
                begin
                    push     = 1'b1;
                    cnt_next = '0;
                end
                default:
                begin
                end
            endcase
            // drop the line state at either end marker
            if (push)
            begin
                seen_next        = 1'b0;
                pos_next         = 4'd0;
                tlen_next        = 4'd0;
                prev_next        = 8'd0;
                tail_last_next   = 8'd0;
                tail_second_next = 8'd0;
                colon_next       = 2'd0;
                allc_next        = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg        <= 1'b0;
            prefix_reg      <= '0;
            pos_reg         <= 4'd0;
            tlen_reg        <= 4'd0;
            prev_reg        <= 8'd0;
            tail_last_reg   <= 8'd0;
            tail_second_reg <= 8'd0;
            colon_reg       <= 2'd0;
            allc_reg        <= 1'b1;
            cnt_reg         <= '0;
        end
        else
        begin
            seen_reg        <= seen_next;
            prefix_reg      <= prefix_next;
            pos_reg         <= pos_next;
            tlen_reg        <= tlen_next;
            prev_reg        <= prev_next;
            tail_last_reg   <= tail_last_next;
            tail_second_reg <= tail_second_next;
            colon_reg       <= colon_next;
            allc_reg        <= allc_next;
            cnt_reg         <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/mlc_queue.sv =====
// Short snapshot queue between the front and the back.
// Depends on mlc_pkg.
`default_nettype none

module mlc_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire mlc_pkg::line_snap_t   push_data,
    input  wire logic                  pop,
    output mlc_pkg::line_snap_t        pop_data,
    output mlc_pkg::queue_status_t     q_status
);

    mlc_pkg::line_snap_t                 mem_reg [mlc_pkg::QUEUE_DEPTH];
    logic [mlc_pkg::QUEUE_PTR_BITS-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [mlc_pkg::QUEUE_CNT_BITS-1:0]  cnt_reg;

    localparam logic [mlc_pkg::QUEUE_PTR_BITS-1:0] LAST_PTR =
        mlc_pkg::QUEUE_PTR_BITS'(mlc_pkg::QUEUE_DEPTH - 1);
    localparam logic [mlc_pkg::QUEUE_CNT_BITS-1:0] FULL_CNT =
        mlc_pkg::QUEUE_CNT_BITS'(mlc_pkg::QUEUE_DEPTH);

    assign q_status.full  = (cnt_reg == FULL_CNT);
    assign q_status.empty = (cnt_reg == '0);
    assign pop_data       = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== sv/mlc_back.sv =====
// Back end: classifies the head snapshot and holds it in the result register.
// Depends on mlc_pkg and mlc_line_if.
`default_nettype none

module mlc_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire mlc_pkg::queue_status_t q_status,
    input  wire mlc_pkg::line_snap_t   head,
    output logic                       pop,
    mlc_line_if.source                 line_result
);

    logic                 out_valid_reg;
    mlc_pkg::line_kind_t  out_kind_reg;
    logic [15:0]          out_num_reg;
    mlc_pkg::line_kind_t  kind;

    function automatic logic starts_with(input mlc_pkg::line_snap_t s,
                                         input logic [mlc_pkg::KEY_BITS-1:0] key,
                                         input int n);
        logic ok;
        ok = (32'(s.tlen) >= n);
        for (int i = 0; i < mlc_pkg::KEY_CHARS; i++)
        begin
            if (i < n)
            begin
                if (s.prefix[i] != key[8*(n-1-i) +: 8])
                    ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic logic equals(input mlc_pkg::line_snap_t s,
                                    input logic [mlc_pkg::KEY_BITS-1:0] key,
                                    input int n);
        return (32'(s.tlen) == n) && starts_with(s, key, n);
    endfunction

    // a run of one to six markers followed by whitespace inside the line
    function automatic logic marker_space(input mlc_pkg::line_snap_t s,
                                          input logic [7:0] m);
        logic hit;
        logic run;
        hit = 1'b0;
        for (int j = 1; j <= 6; j++)
        begin
            run = 1'b1;
            for (int k = 0; k < j; k++)
            begin
                if (s.prefix[k] != m)
                    run = 1'b0;
            end
            if (run && (32'(s.tlen) > j) && mlc_pkg::is_space(s.prefix[j]))
                hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic mlc_pkg::line_kind_t classify(input mlc_pkg::line_snap_t s);
        logic [7:0] p0;
        logic [7:0] p1;
        logic       two;
        mlc_pkg::line_kind_t k;
        p0  = s.prefix[0];
        p1  = s.prefix[1];
        two = (s.tlen >= 4'd2);
        if (s.is_eof)
            k = mlc_pkg::KIND_EOF;
        else if (!s.seen)
            k = mlc_pkg::KIND_BLANK;
        else if (starts_with(s, "[[", 2) && (s.tail_second == "]") && (s.tail_last == "]"))
            k = mlc_pkg::KIND_ANCHOR;
        else if (two && (p0 == "[") && (s.tail_last == "]") && (p1 != "["))
            k = mlc_pkg::KIND_ATTRS;
        else if (two && (p0 == ".") && (p1 != ".") && !mlc_pkg::is_space(p1))
            k = mlc_pkg::KIND_TITLE;
        else if (starts_with(s, "ifdef::", 7) || starts_with(s, "ifndef::", 8)
                 || starts_with(s, "endif::", 7))
            k = mlc_pkg::KIND_DIRECTIVE;
        else if ((s.tlen >= 4'd3) && (s.colon_run >= 2'd2) && !s.all_colons)
            k = mlc_pkg::KIND_DESCTERM;
        else if (starts_with(s, "include::", 9))
            k = mlc_pkg::KIND_MACRO;
        else if (starts_with(s, "//", 2) && !equals(s, "////", 4))
            k = mlc_pkg::KIND_COMMENT;
        else if (equals(s, "'''", 3))
            k = mlc_pkg::KIND_THEMATIC;
        else if (starts_with(s, "<<<", 3))
            k = mlc_pkg::KIND_PAGEBREAK;
        else if (marker_space(s, "="))
            k = mlc_pkg::KIND_SECTION;
        else if (marker_space(s, "*"))
            k = mlc_pkg::KIND_UL;
        else if (marker_space(s, "."))
            k = mlc_pkg::KIND_OL;
        else if (equals(s, "+", 1))
            k = mlc_pkg::KIND_CONT;
        else if (equals(s, "|===", 4))
            k = mlc_pkg::KIND_TABLE_DELIM;
        else if (p0 == "|")
            k = mlc_pkg::KIND_TABLE_LINE;
        else if (equals(s, "----", 4))
            k = mlc_pkg::KIND_LISTING;
        else if (equals(s, "....", 4))
            k = mlc_pkg::KIND_LITERAL;
        else if (equals(s, "____", 4))
            k = mlc_pkg::KIND_QUOTE;
        else if (equals(s, "====", 4))
            k = mlc_pkg::KIND_EXAMPLE;
        else if (equals(s, "****", 4))
            k = mlc_pkg::KIND_SIDEBAR;
        else if (equals(s, "--", 2))
            k = mlc_pkg::KIND_OPEN;
        else if (equals(s, "////", 4))
            k = mlc_pkg::KIND_COMMENT_BLOCK;
        else if (starts_with(s, "NOTE:", 5) || starts_with(s, "TIP:", 4)
                 || starts_with(s, "IMPORTANT:", 10) || starts_with(s, "CAUTION:", 8)
                 || starts_with(s, "WARNING:", 8))
            k = mlc_pkg::KIND_ADMONITION;
        else
            k = mlc_pkg::KIND_TEXT;
        return k;
    endfunction

    assign kind = classify(head);
    // advance the head whenever the result register is free or being emptied
    assign pop  = !q_status.empty && (!out_valid_reg || line_result.ready);

    assign line_result.valid       = out_valid_reg;
    assign line_result.line_kind   = out_kind_reg;
    assign line_result.line_number = out_num_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_kind_reg <= kind;
            out_num_reg  <= head.line_number;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop)
            out_valid_reg <= 1'b1;
        else if (line_result.ready)
            out_valid_reg <= 1'b0;
    end

endmodule

`default_nettype wire

// ===== sv/markup_line_classifier.sv =====
// Top level of the markup line classifier: front end, snapshot queue, back end.
// Depends on mlc_pkg, mlc_if, mlc_front, mlc_queue, mlc_back and the defines header.
`default_nettype none
`include "markup_line_classifier_defines.svh"

// The block takes a text one item per clock: a byte, an end of line or an end
// of text. Each end of line gives one result item with the line's kind and its
// one-based number; an end of text gives kind EOF with the next number and
// restarts numbering at one. Whitespace (bytes 9 to 13 and 32) is trimmed at
// both ends of each line before classification. Byte items cause no result.
// An item is taken whenever the snapshot queue is not full; with the result
// register free, the snapshot of an end of line is queued and then registered
// as a result. The front end updates the line state and
// pushes a snapshot into a two-entry queue; the back end classifies the head of
// the queue with parallel compares straight into the result register. The input
// stalls only when that queue is full, which takes a result held back by the
// sink, so with a ready sink the sustained rate is one item per cycle.
module markup_line_classifier (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mlc_byte_if.sink    byte_stream,
    mlc_line_if.source  line_result
);

    mlc_pkg::queue_status_t  q_status;
    mlc_pkg::line_snap_t     push_data;
    mlc_pkg::line_snap_t     head;
    logic                    push;
    logic                    pop;

    // Front: trim and record the line, hand over a snapshot at each end marker.
    mlc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_stream(byte_stream),
        .q_status   (q_status),
        .push       (push),
        .push_data  (push_data)
    );

    // Queue: decouple the byte side from a stalled result.
    mlc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .pop_data   (head),
        .q_status   (q_status)
    );

    // Back: classify the head and hold the result until taken.
    mlc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .head       (head),
        .pop        (pop),
        .line_result(line_result)
    );

    // An accepted end marker always leaves something queued.
    `MLC_ASSERT_NEXT(a_marker_queued, clk, rst_n, push, !q_status.empty)
    // A queued snapshot moves into a free result register at once.
    `MLC_ASSERT_NEXT(a_head_moves, clk, rst_n, !q_status.empty && !line_result.valid, line_result.valid)
    // The queue fills only behind a result that waits to be taken.
    `MLC_ASSERT_IMPL(a_full_needs_result, clk, rst_n, q_status.full, line_result.valid)

endmodule

`default_nettype wire
